// ===== sv/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, opcodes, error codes and register indexes of the stack
// machine executor.
// ----------------------------------------------------------------------------
package svm_pkg;

	typedef logic [31:0] word_t;
	typedef logic signed [31:0] sword_t;
	typedef logic [4:0] opcode_t;
	typedef logic [2:0] err_t;

	// default operand stack depth
	localparam int STACK_DEPTH_DEF = 256;

	// register file layout
	localparam int NUM_REGS = 9;
	localparam logic [3:0] REG_SP = 4'd6;
	localparam logic [3:0] REG_PC = 4'd7;
	localparam logic [3:0] REG_TM = 4'd8;

	// item kinds
	localparam logic OPER_EXEC = 1'b0;
	localparam logic OPER_TICK = 1'b1;

	// opcodes
	localparam opcode_t OP_PUSH = 5'd0;
	localparam opcode_t OP_POP  = 5'd1;
	localparam opcode_t OP_PEEK = 5'd2;
	localparam opcode_t OP_ADD  = 5'd3;
	localparam opcode_t OP_SUB  = 5'd4;
	localparam opcode_t OP_MUL  = 5'd5;
	localparam opcode_t OP_DIV  = 5'd6;
	localparam opcode_t OP_SET  = 5'd7;
	localparam opcode_t OP_PSET = 5'd8;
	localparam opcode_t OP_GET  = 5'd9;
	localparam opcode_t OP_MOV  = 5'd10;
	localparam opcode_t OP_JMP  = 5'd11;
	localparam opcode_t OP_JEQ  = 5'd12;
	localparam opcode_t OP_JNE  = 5'd13;
	localparam opcode_t OP_JLT  = 5'd14;
	localparam opcode_t OP_JGT  = 5'd15;
	localparam opcode_t OP_NOP  = 5'd16;
	localparam opcode_t OP_HALT = 5'd17;

	// error codes
	localparam err_t ERR_NONE    = 3'd0;
	localparam err_t ERR_DIVZERO = 3'd1;
	localparam err_t ERR_FULL    = 3'd2;
	localparam err_t ERR_EMPTY   = 3'd3;
	localparam err_t ERR_OPCODE  = 3'd4;
	localparam err_t ERR_BADREG  = 3'd5;

endpackage

// ===== sv/svm_stack.sv =====
// ----------------------------------------------------------------------------
// svm_stack
// Operand stack storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module svm_stack #(
	parameter int DEPTH = svm_pkg::STACK_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  svm_pkg::word_t      wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr_a,
	input  logic [AW-1:0]       rd_addr_b,
	output svm_pkg::word_t      rd_data_a,
	output svm_pkg::word_t      rd_data_b
);
	import svm_pkg::*;

	word_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read ports, data held between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== sv/svm_div.sv =====
// ----------------------------------------------------------------------------
// svm_div
// Signed 32-bit divider truncating toward zero, restoring, one quotient bit
// per cycle on magnitudes with the sign applied at the output.
// ----------------------------------------------------------------------------
module svm_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  svm_pkg::word_t dividend,
	input  svm_pkg::word_t divisor,
	output logic           done,
	output svm_pkg::word_t quotient
);
	import svm_pkg::*;

	logic       busy_q;
	logic       done_q;
	logic [4:0] cnt_q;
	logic       neg_q;
	word_t      den_q;
	word_t      rem_q;
	word_t      quo_q;
	logic [32:0] trial;

	// trial subtraction of the divisor from the shifted remainder
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[31] ^ divisor[31];
			den_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

// ===== sv/stack_vm_execute.sv =====
// ----------------------------------------------------------------------------
// stack_vm_execute
// Stack machine instruction executor with a countdown timer register.
//
// Input channel (in_valid / in_stall) carries one instruction or one timer
// tick per transaction; the output channel (out_valid / out_stall) returns
// exactly one result transaction per input transaction, in order.
// After reset the block clears the operand stack memory, one entry a cycle,
// through the last address; in_stall stays high during that sweep.
// For an item, the accept cycle reads the two top stack entries from the
// synchronous memory, and the execute state then executes and writes back.
// A divide also waits in the divide state for the bit-serial divider.
// The result sits in an output register; when the receiver stalls, the next
// transaction is still accepted and waits in the execute cycle until the
// output register frees. Items run one at a time.
// Reset sets all registers to zero, the stack pointer to -1, running to one
// and the latched error to none. A halt or an error freezes the block until
// the next reset; later items only report the current pc and status.
// ----------------------------------------------------------------------------
module stack_vm_execute #(
	parameter int STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  svm_pkg::opcode_t    opcode,
	input  svm_pkg::sword_t     arg1,
	input  svm_pkg::sword_t     arg2,
	output logic                out_valid,
	input  logic                out_stall,
	output svm_pkg::sword_t     next_pc,
	output logic                peek_valid,
	output svm_pkg::sword_t     peek_value,
	output logic                halted,
	output svm_pkg::err_t       error_code
);
	import svm_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam word_t DEPTH_W = 32'(STACK_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(STACK_DEPTH - 1);

	// sequencer states
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_DIV   = 2'd3;

	logic [1:0]    state_q;
	logic [AW-1:0] clr_cnt_q;

	// architectural state
	word_t regs_q [NUM_REGS];
	logic  running_q;
	err_t  lat_err_q;

	// captured transaction
	logic    oper_q;
	opcode_t opc_q;
	word_t   a1_q;
	word_t   a2_q;

	logic div_done_q;

	// output register
	logic  out_valid_q;
	word_t next_pc_q;
	logic  peek_valid_q;
	word_t peek_value_q;
	logic  halted_q;
	err_t  error_code_q;

	// memory and divider hookup
	logic          in_acc;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	word_t         mem_wd;
	word_t         rd_y;
	word_t         rd_x;
	logic          div_done;
	word_t         div_quot;

	// execute stage
	word_t   sp;
	word_t   depth;
	word_t   sp_in;
	logic    sp_bad;
	err_t    need1_err;
	err_t    need2_err;
	err_t    room_err;
	logic    bad1;
	logic    bad2;
	logic [3:0] src_idx;
	word_t   src_val;
	word_t   arith;
	word_t   tm;
	err_t    err;
	logic    jump;
	logic    halt;
	logic    pk_v;
	logic    div_go;
	logic    ex_we;
	logic [AW-1:0] ex_wa;
	word_t   ex_wd;
	word_t   regs_n [NUM_REGS];
	logic    out_free;
	logic    commit;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// stack pointer and depth checks
	assign sp     = regs_q[REG_SP];
	assign sp_in  = sp - 32'd1;
	assign depth  = sp + 32'd1;
	assign sp_bad = depth > DEPTH_W;
	assign need1_err = sp_bad ? ERR_BADREG : ((depth == 32'd0) ? ERR_EMPTY : ERR_NONE);
	assign need2_err = sp_bad ? ERR_BADREG : ((depth < 32'd2) ? ERR_EMPTY : ERR_NONE);
	assign room_err  = sp_bad ? ERR_BADREG : ((depth == DEPTH_W) ? ERR_FULL : ERR_NONE);

	// register operand checks and source select
	assign bad1    = a1_q >= 32'(NUM_REGS);
	assign bad2    = a2_q >= 32'(NUM_REGS);
	assign src_idx = (opc_q == OP_MOV) ? a2_q[3:0] : a1_q[3:0];
	assign src_val = regs_q[src_idx];
	assign tm      = regs_q[REG_TM];

	// arithmetic on the two top entries
	always_comb begin
		case (opc_q)
			OP_ADD:  arith = rd_x + rd_y;
			OP_SUB:  arith = rd_x - rd_y;
			OP_MUL:  arith = rd_x * rd_y;
			default: arith = div_quot;
		endcase
	end

	// instruction decode and next register state
	always_comb begin
		err    = ERR_NONE;
		jump   = 1'b0;
		halt   = 1'b0;
		pk_v   = 1'b0;
		div_go = 1'b0;
		ex_we  = 1'b0;
		ex_wa  = depth[AW-1:0];
		ex_wd  = a1_q;
		for (int i = 0; i < NUM_REGS; i++) begin
			regs_n[i] = regs_q[i];
		end
		if (running_q && oper_q == OPER_TICK) begin
			if (!tm[31] && tm != 32'd0) begin
				regs_n[REG_TM] = tm - 32'd1;
			end
		end else if (running_q) begin
			unique case (opc_q) inside
				OP_PUSH: begin
					err = room_err;
					if (err == ERR_NONE) begin
						ex_we = 1'b1;
						regs_n[REG_SP] = depth;
					end
				end
				OP_POP: begin
					err = need1_err;
					if (err == ERR_NONE) begin
						regs_n[REG_SP] = sp_in;
					end
				end
				OP_PEEK: begin
					err = need1_err;
					pk_v = (err == ERR_NONE);
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					err = need1_err;
					if (err == ERR_NONE && opc_q == OP_DIV && rd_y == 32'd0) begin
						err = ERR_DIVZERO;
					end
					if (err == ERR_NONE) begin
						err = need2_err;
					end
					if (err == ERR_NONE) begin
						if (opc_q == OP_DIV && !div_done_q) begin
							div_go = 1'b1;
						end else begin
							ex_we = 1'b1;
							ex_wa = sp_in[AW-1:0];
							ex_wd = arith;
							regs_n[REG_SP] = sp_in;
						end
					end
				end
				OP_SET: begin
					if (bad1) begin
						err = ERR_BADREG;
					end else begin
						regs_n[a1_q[3:0]] = a2_q;
					end
				end
				OP_PSET: begin
					err = bad1 ? ERR_BADREG : need1_err;
					if (err == ERR_NONE) begin
						regs_n[REG_SP] = sp_in;
						regs_n[a1_q[3:0]] = rd_y;
					end
				end
				OP_GET: begin
					err = bad1 ? ERR_BADREG : room_err;
					if (err == ERR_NONE) begin
						ex_we = 1'b1;
						ex_wd = src_val;
						regs_n[REG_SP] = depth;
					end
				end
				OP_MOV: begin
					if (bad1 || bad2) begin
						err = ERR_BADREG;
					end else begin
						regs_n[a1_q[3:0]] = src_val;
					end
				end
				OP_JMP: begin
					jump = 1'b1;
				end
				OP_JEQ, OP_JNE, OP_JLT, OP_JGT: begin
					err = need2_err;
					if (err == ERR_NONE) begin
						regs_n[REG_SP] = sp - 32'd2;
						case (opc_q)
							OP_JEQ:  jump = (rd_x == rd_y);
							OP_JNE:  jump = (rd_x != rd_y);
							OP_JLT:  jump = ($signed(rd_x) < $signed(rd_y));
							default: jump = ($signed(rd_y) < $signed(rd_x));
						endcase
					end
				end
				OP_NOP: begin
				end
				OP_HALT: begin
					halt = 1'b1;
				end
				default: begin
					err = ERR_OPCODE;
				end
			endcase
			// pc advance
			if (err == ERR_NONE) begin
				regs_n[REG_PC] = jump ? a1_q : (regs_n[REG_PC] + 32'd1);
			end
		end
	end

	assign commit = (state_q == S_EXEC) && !div_go && out_free;

	// memory write select: clearing sweep or execute write-back
	assign mem_we = (state_q == S_CLEAR) || (commit && ex_we && err == ERR_NONE);
	assign mem_wa = (state_q == S_CLEAR) ? clr_cnt_q : ex_wa;
	assign mem_wd = (state_q == S_CLEAR) ? '0 : ex_wd;

	svm_stack #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk       (clk),
		.wr_en     (mem_we),
		.wr_addr   (mem_wa),
		.wr_data   (mem_wd),
		.rd_en     (in_acc),
		.rd_addr_a (regs_q[REG_SP][AW-1:0]),
		.rd_addr_b (sp_in[AW-1:0]),
		.rd_data_a (rd_y),
		.rd_data_b (rd_x)
	);

	svm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go && state_q == S_EXEC),
		.dividend (rd_x),
		.divisor  (rd_y),
		.done     (div_done),
		.quotient (div_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_cnt_q  <= '0;
			div_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (div_go) begin
						state_q <= S_DIV;
					end else if (commit) begin
						state_q    <= S_IDLE;
						div_done_q <= 1'b0;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q    <= S_EXEC;
						div_done_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// transaction capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			oper_q <= operation;
			opc_q  <= opcode;
			a1_q   <= arg1;
			a2_q   <= arg2;
		end
	end

	// architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// stack pointer starts at -1, everything else at zero
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= (i == int'(REG_SP)) ? 32'hffff_ffff : 32'd0;
			end
			running_q <= 1'b1;
			lat_err_q <= ERR_NONE;
		end else if (commit) begin
			if (err != ERR_NONE) begin
				lat_err_q <= err;
				running_q <= 1'b0;
			end else begin
				for (int i = 0; i < NUM_REGS; i++) begin
					regs_q[i] <= regs_n[i];
				end
				if (halt) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			next_pc_q    <= (err != ERR_NONE) ? regs_q[REG_PC] : regs_n[REG_PC];
			peek_valid_q <= pk_v;
			peek_value_q <= pk_v ? rd_y : '0;
			halted_q     <= !running_q || halt || (err != ERR_NONE);
			error_code_q <= (err != ERR_NONE) ? err : lat_err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_pc    = next_pc_q;
	assign peek_valid = peek_valid_q;
	assign peek_value = peek_value_q;
	assign halted     = halted_q;
	assign error_code = error_code_q;

`ifndef SYNTH
	// a latched error always goes with a stopped machine
	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(lat_err_q != ERR_NONE) |-> !running_q)
		else $error("error latched while running");

	// once stopped, the machine stays stopped
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |=> !running_q)
		else $error("machine restarted without reset");

	// the divider never starts on a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(div_go && state_q == S_EXEC) |-> (rd_y != 32'd0))
		else $error("divider started on zero divisor");

	// a new result only comes out of the execute cycle
	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EXEC))
		else $error("result produced outside execute");
`endif

endmodule
